>>> rtl/tpps_pkg.sv
package tpps_pkg;

  // fixed field widths
  localparam int unsigned RateW  = 32;
  localparam int unsigned ClockW = 32;
  localparam int unsigned PscW   = 16;
  localparam int unsigned PerW   = 16;

  // trial divisor can reach clock + rate before the search stops
  localparam int unsigned DivisorW = ClockW + 1;

  // divider step counter
  localparam int unsigned StepW = $clog2(ClockW);

  // request to the divider
  typedef struct packed {
    logic              start;
    logic [ClockW-1:0] dividend;
    logic [ClockW-1:0] divisor;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic              done;
    logic [ClockW-1:0] quot;
    logic              rem_zero;
  } div_rsp_t;

endpackage

>>> rtl/timer_prescale_period_search.sv
// Timer prescale and period search.
// A beat on the s_axis side carries a wanted update rate in hertz. The block
// tries prescale values p = 1, 2, ... and returns the first one for which the
// configured timer clock divides exactly by (p+1)*rate with a period
// (quotient minus one) of at most PERIOD_MAX. One beat on the m_axis side
// answers each input beat: prescale and period in tdata, found in tuser.
// No match, a zero rate, or reaching PRESCALE_LIMIT gives zeros, found low.
// The clock frequency is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, as the block does not enforce it. Reset loads 72000000.
// Each trial is one compare in StCheck, then 32 steps of the radix-2 divider,
// then one check of its result. The search stops as soon as the trial
// divisor exceeds the clock.
// s_axis_tready_o stays low while a search runs. A finished result goes to
// an output register; when the receiver stalls, the next search can run but
// waits before loading its result until the register is free.
// Reset clears the sequencer and the output valid at once.
module timer_prescale_period_search #(
  parameter int unsigned PRESCALE_LIMIT = 65535,
  parameter int unsigned PERIOD_MAX     = 65535
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: clock_hz
  input  logic                            cfg_we_i,
  input  logic [tpps_pkg::ClockW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [31:0]                     s_axis_tdata_i,  // [31:0] target_hz
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [31:0]                     m_axis_tdata_o,  // [15:0] prescale, [31:16] period
  output logic                            m_axis_tuser_o   // [0] found
);
  import tpps_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StDivide = 3'd2;
  localparam logic [2:0] StFinish = 3'd3;
  localparam logic [2:0] StWait   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [ClockW-1:0]   clock_hz_q;
  logic [RateW-1:0]    rate_q, rate_d;
  logic [PscW-1:0]     psc_q, psc_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [PscW-1:0]     res_psc_q, res_psc_d;
  logic [PerW-1:0]     res_per_q, res_per_d;
  logic                res_found_q, res_found_d;
  logic                out_valid_q, out_valid_d;
  logic [PscW-1:0]     out_psc_q, out_psc_d;
  logic [PerW-1:0]     out_per_q, out_per_d;
  logic                out_found_q, out_found_d;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [ClockW-1:0]   quot_m1;
  logic                accept;
  logic                out_free;

  tpps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign quot_m1         = div_rsp.quot - 1'b1;

  // clock frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= ClockW'(72000000);
    end else if (cfg_we_i) begin
      clock_hz_q <= cfg_wdata_i;
    end
  end

  // search sequencer
  always_comb begin
    state_d      = state_q;
    rate_d       = rate_q;
    psc_d        = psc_q;
    dvs_d        = dvs_q;
    res_psc_d    = res_psc_q;
    res_per_d    = res_per_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_psc_d    = out_psc_q;
    out_per_d    = out_per_q;
    out_found_d  = out_found_q;
    div_req.start    = 1'b0;
    div_req.dividend = clock_hz_q;
    div_req.divisor  = dvs_q[ClockW-1:0];

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          rate_d      = s_axis_tdata_i[RateW-1:0];
          psc_d       = PscW'(1);
          dvs_d       = {s_axis_tdata_i[RateW-1:0], 1'b0};
          res_psc_d   = '0;
          res_per_d   = '0;
          res_found_d = 1'b0;
          state_d     = (s_axis_tdata_i[RateW-1:0] == '0) ? StFinish : StCheck;
        end
      end
      StCheck: begin
        // stop at the limit or once the divisor passes the clock
        if (psc_q >= PscW'(PRESCALE_LIMIT) ||
            dvs_q > {1'b0, clock_hz_q}) begin
          state_d = StFinish;
        end else begin
          div_req.start = 1'b1;
          state_d       = StDivide;
        end
      end
      StDivide: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero && quot_m1 <= ClockW'(PERIOD_MAX)) begin
            res_psc_d   = psc_q;
            res_per_d   = quot_m1[PerW-1:0];
            res_found_d = 1'b1;
            state_d     = StFinish;
          end else begin
            psc_d   = psc_q + 1'b1;
            dvs_d   = dvs_q + {1'b0, rate_q};
            state_d = StCheck;
          end
        end
      end
      StFinish: begin
        state_d = StWait;
      end
      StWait: begin
        // load the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_psc_d   = res_psc_q;
          out_per_d   = res_per_q;
          out_found_d = res_found_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rate_q      <= rate_d;
    psc_q       <= psc_d;
    dvs_q       <= dvs_d;
    res_psc_q   <= res_psc_d;
    res_per_q   <= res_per_d;
    res_found_q <= res_found_d;
    out_psc_q   <= out_psc_d;
    out_per_q   <= out_per_d;
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_per_q, out_psc_q};
  assign m_axis_tuser_o  = out_found_q;

endmodule

>>> rtl/tpps_div.sv
module tpps_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpps_pkg::div_req_t req_i,
  output tpps_pkg::div_rsp_t rsp_o
);
  import tpps_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [ClockW-1:0] rem_q, rem_d;
  logic [ClockW-1:0] dq_q, dq_d;
  logic [ClockW-1:0] dvs_q, dvs_d;

  logic [ClockW:0]   trial;
  logic [ClockW:0]   diff;
  logic              ge;

  // one restoring step: shift in next dividend bit, try to subtract
  assign trial = {rem_q, dq_q[ClockW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dq_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? diff[ClockW-1:0] : trial[ClockW-1:0];
      dq_d   = {dq_q[ClockW-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(ClockW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quot     = dq_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule
